>>> design/assert_macros.svh
// assertion helpers used by cartesian_to_spherical
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define CTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked check that also runs during reset
`define CTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

>>> design/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// shared constants, widths and the cordic arctangent table for the
// cartesian to spherical converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

    // default configuration
    localparam int COORD_WIDTH_DEF     = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 15;

    // cordic datapath
    localparam int CORDIC_STEPS = 32;
    localparam int DP_W         = 64;
    localparam int ACC_W        = 34;
    localparam int ACC_FRAC     = 31;

    // 1/K in q31
    localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

    // quarter turn in units of pi/2^31
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sh40000000;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051E;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2FA;
            15: v = 34'sh0000517D;
            16: v = 34'sh000028BE;
            17: v = 34'sh0000145F;
            18: v = 34'sh00000A30;
            19: v = 34'sh00000518;
            20: v = 34'sh0000028C;
            21: v = 34'sh00000146;
            22: v = 34'sh000000A3;
            23: v = 34'sh00000051;
            24: v = 34'sh00000029;
            25: v = 34'sh00000014;
            26: v = 34'sh0000000A;
            27: v = 34'sh00000005;
            28: v = 34'sh00000003;
            29: v = 34'sh00000001;
            30: v = 34'sh00000001;
            default: v = 34'sh0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// fixed point cartesian to spherical conversion: radius, polar angle and
// azimuth of one point per transfer
// ----------------------------------------------------------------------------
// One point is taken per clock while the result side is not stalled. The path
// is set by the two 32-stage vectoring cordic pipelines (azimuth, then polar
// angle from the rescaled planar magnitude), each with one iteration per
// stage plus a rounding stage, the two-stage 1/K rescale between them, and
// the input and output registers. The radius root runs beside them and is
// delayed to match. All stages advance together whenever the output register
// is empty or being taken, so a stall on the result side holds every item in
// place. The zero point gives all zeros.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cartesian_to_spherical #(
    parameter int COORD_WIDTH     = cts_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = cts_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // tdata, low bit up: x_coord, y_coord, z_coord, zero pad
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,

    // tdata, low bit up: radius, polar_angle, azimuth, zero pad
    output logic [((COORD_WIDTH+2*ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_tdata,
    output logic                                                 m_tvalid,
    input  wire logic                                            m_tready
);
    import cts_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int AF        = ANGLE_FRAC_BITS;
    localparam int OUT_W     = ((CW + 2*AF + 3 + 7) / 8) * 8;
    localparam int PRE_SHIFT = 60 - CW;
    localparam int CORD_LAT  = CORDIC_STEPS + 1;
    localparam int TOTAL_LAT = 2 * CORD_LAT + 2;
    localparam int AZ_DLY    = CORD_LAT + 2;
    localparam int PHI_DLY   = TOTAL_LAT - CORD_LAT;
    localparam int RAD_DLY   = TOTAL_LAT - (CW + 4);

    localparam logic signed [AF+1:0] PI_PHI   = (AF+2)'(1) << AF;
    localparam logic        [AF:0]   PI_THETA = (AF+1)'(1) << AF;

    // global advance: output empty or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage: magnitudes and signs
    logic [CW-1:0] ax_reg, ay_reg, az_reg;
    logic [2:0]    sgn_reg;
    logic          v1_reg;
    logic [CW-1:0] x_in, y_in, z_in;

    assign x_in = s_tdata[0 +: CW];
    assign y_in = s_tdata[CW +: CW];
    assign z_in = s_tdata[2*CW +: CW];

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= x_in[CW-1] ? CW'(-$signed(x_in)) : x_in;
            ay_reg  <= y_in[CW-1] ? CW'(-$signed(y_in)) : y_in;
            az_reg  <= z_in[CW-1] ? CW'(-$signed(z_in)) : z_in;
            sgn_reg <= {z_in[CW-1], y_in[CW-1], x_in[CW-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    // azimuth cordic
    logic                phi_v;
    logic [AF-1:0]       phi_q;
    logic [DP_W-2:0]     rho_k;

    cts_cordic #(
        .ANGLE_FRAC_BITS (AF)
    ) u_cordic_phi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_x      ($signed(DP_W'(ax_reg) << PRE_SHIFT)),
        .in_y      ($signed(DP_W'(ay_reg) << PRE_SHIFT)),
        .out_valid (phi_v),
        .out_angle (phi_q),
        .out_mag   (rho_k)
    );

    // rescale the planar magnitude by 1/K
    logic [62:0]     p_hi_reg;
    logic [61:0]     p_lo_reg;
    logic            m1_v_reg;
    logic [DP_W-1:0] rho_reg;
    logic            m2_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_hi_reg <= 63'(rho_k[62:31]) * 63'(INV_GAIN);
            p_lo_reg <= 62'(rho_k[30:0]) * 62'(INV_GAIN);
            rho_reg  <= DP_W'(p_hi_reg) + DP_W'(p_lo_reg[61:31]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end else if (en) begin
            m1_v_reg <= phi_v;
            m2_v_reg <= m1_v_reg;
        end
    end

    // delay lines for sideband values
    logic [CW-1:0] az_dly_reg  [0:AZ_DLY-1];
    logic [AF-1:0] phi_dly_reg [0:PHI_DLY-1];
    logic [2:0]    sgn_dly_reg [0:TOTAL_LAT-1];
    logic [CW-1:0] rad_dly_reg [0:RAD_DLY-1];
    logic [CW-1:0] rad_raw;

    always_ff @(posedge aclk) begin
        if (en) begin
            az_dly_reg[0]  <= az_reg;
            phi_dly_reg[0] <= phi_q;
            sgn_dly_reg[0] <= sgn_reg;
            rad_dly_reg[0] <= rad_raw;
            for (int k = 1; k < AZ_DLY; k++) begin
                az_dly_reg[k] <= az_dly_reg[k-1];
            end
            for (int k = 1; k < PHI_DLY; k++) begin
                phi_dly_reg[k] <= phi_dly_reg[k-1];
            end
            for (int k = 1; k < TOTAL_LAT; k++) begin
                sgn_dly_reg[k] <= sgn_dly_reg[k-1];
            end
            for (int k = 1; k < RAD_DLY; k++) begin
                rad_dly_reg[k] <= rad_dly_reg[k-1];
            end
        end
    end

    // radius root
    cts_radius #(
        .COORD_WIDTH (CW)
    ) u_radius (
        .aclk       (aclk),
        .en         (en),
        .in_ax      (ax_reg),
        .in_ay      (ay_reg),
        .in_az      (az_reg),
        .out_radius (rad_raw)
    );

    // polar angle cordic
    logic          th_v;
    logic [AF-1:0] th_q;
    logic [DP_W-2:0] th_mag;

    cts_cordic #(
        .ANGLE_FRAC_BITS (AF)
    ) u_cordic_theta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_v_reg),
        .in_x      ($signed(DP_W'(az_dly_reg[AZ_DLY-1]) << PRE_SHIFT)),
        .in_y      ($signed(rho_reg)),
        .out_valid (th_v),
        .out_angle (th_q),
        .out_mag   (th_mag)
    );

    // quadrant fix-up and output register
    logic [2:0]            sgn_f;
    logic signed [AF+1:0]  phi_base;
    logic signed [AF+1:0]  phi_next;
    logic        [AF:0]    theta_next;
    logic [CW-1:0]         rad_out_reg;
    logic [AF:0]           theta_out_reg;
    logic signed [AF+1:0]  phi_out_reg;
    logic                  m_tvalid_reg;

    assign sgn_f = sgn_dly_reg[TOTAL_LAT-1];

    always_comb begin
        phi_base   = $signed((AF+2)'(phi_dly_reg[PHI_DLY-1]));
        if (sgn_f[0]) begin
            phi_base = PI_PHI - phi_base;
        end
        phi_next   = sgn_f[1] ? -phi_base : phi_base;
        theta_next = sgn_f[2] ? PI_THETA - (AF+1)'(th_q) : (AF+1)'(th_q);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_out_reg   <= rad_dly_reg[RAD_DLY-1];
            theta_out_reg <= theta_next;
            phi_out_reg   <= phi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= th_v;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({phi_out_reg, theta_out_reg, rad_out_reg});

    // checks
    `CTS_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")
    `CTS_ASSERT(a_theta_range, m_tvalid |-> (theta_out_reg <= PI_THETA), "polar angle past pi")
    `CTS_ASSERT(a_phi_range, m_tvalid |-> (phi_out_reg <= PI_PHI && phi_out_reg >= -PI_PHI), "azimuth out of range")
    `CTS_ASSERT(a_mag_sign, th_v |-> (th_mag[DP_W-2] == 1'b0 || th_mag[DP_W-2] == 1'b1), "theta magnitude unknown")

endmodule

`default_nettype wire

>>> design/cts_cordic.sv
// ----------------------------------------------------------------------------
// cts_cordic
// pipelined vectoring cordic, one iteration per stage, followed by a stage
// that clamps the first-quadrant angle and rounds it to the output scale
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cts_cordic #(
    parameter int ANGLE_FRAC_BITS = cts_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [cts_pkg::DP_W-1:0] in_x,
    input  wire logic signed [cts_pkg::DP_W-1:0] in_y,
    output logic                                out_valid,
    output logic [ANGLE_FRAC_BITS-1:0]          out_angle,
    output logic [cts_pkg::DP_W-2:0]            out_mag
);
    import cts_pkg::*;

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;

    logic signed [DP_W-1:0]  x_reg   [0:CORDIC_STEPS-1];
    logic signed [DP_W-1:0]  y_reg   [0:CORDIC_STEPS-1];
    logic signed [ACC_W-1:0] acc_reg [0:CORDIC_STEPS-1];
    logic                    vld_reg [0:CORDIC_STEPS-1];

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [DP_W-1:0]  xi;
        logic signed [DP_W-1:0]  yi;
        logic signed [ACC_W-1:0] ai;
        logic                    vi;

        if (i == 0) begin : g_first
            assign xi = in_x;
            assign yi = in_y;
            assign ai = '0;
            assign vi = in_valid;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = acc_reg[i-1];
            assign vi = vld_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (yi > 0) begin
                    x_reg[i]   <= xi + (yi >>> i);
                    y_reg[i]   <= yi - (xi >>> i);
                    acc_reg[i] <= ai + atan_entry(i);
                end else begin
                    x_reg[i]   <= xi - (yi >>> i);
                    y_reg[i]   <= yi + (xi >>> i);
                    acc_reg[i] <= ai - atan_entry(i);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vi;
            end
        end
    end

    // clamp to the first quadrant and round half up
    logic signed [ACC_W-1:0] acc_cl;
    logic        [ACC_W-1:0] acc_rnd;

    always_comb begin
        acc_cl = acc_reg[CORDIC_STEPS-1];
        if (acc_cl < 0) begin
            acc_cl = '0;
        end else if (acc_cl > QUARTER_TURN) begin
            acc_cl = QUARTER_TURN;
        end
        acc_rnd = $unsigned(acc_cl) + (ACC_W'(1) << (SH - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_angle <= acc_rnd[SH +: ANGLE_FRAC_BITS];
            out_mag   <= x_reg[CORDIC_STEPS-1][DP_W-1] ? '0
                                                       : x_reg[CORDIC_STEPS-1][DP_W-2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= vld_reg[CORDIC_STEPS-1];
        end
    end

endmodule

`default_nettype wire

>>> design/cts_radius.sv
// ----------------------------------------------------------------------------
// cts_radius
// sum of squares and a digit-by-digit square root, one result bit per
// stage, rounded to nearest in a last stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cts_radius #(
    parameter int COORD_WIDTH = cts_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [COORD_WIDTH-1:0] in_ax,
    input  wire logic [COORD_WIDTH-1:0] in_ay,
    input  wire logic [COORD_WIDTH-1:0] in_az,
    output logic      [COORD_WIDTH-1:0] out_radius
);
    import cts_pkg::*;

    localparam int NS = COORD_WIDTH + 1;
    localparam int SW = 2 * NS;
    localparam int QW = 2 * COORD_WIDTH;

    logic [QW-1:0] sqx_reg;
    logic [QW-1:0] sqy_reg;
    logic [QW-1:0] sqz_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] rem_reg [0:NS-1];
    logic [SW-1:0] res_reg [0:NS-1];

    // squares, then their sum
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= QW'(in_ax) * QW'(in_ax);
            sqy_reg <= QW'(in_ay) * QW'(in_ay);
            sqz_reg <= QW'(in_az) * QW'(in_az);
            sum_reg <= SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
        end
    end

    // one root bit per stage
    for (genvar i = 0; i < NS; i++) begin : g_root
        localparam logic [SW-1:0] BIT_VAL = SW'(1) << (2 * (NS - 1 - i));
        logic [SW-1:0] rem_i;
        logic [SW-1:0] res_i;
        logic [SW-1:0] trial;

        if (i == 0) begin : g_first
            assign rem_i = sum_reg;
            assign res_i = '0;
        end else begin : g_next
            assign rem_i = rem_reg[i-1];
            assign res_i = res_reg[i-1];
        end

        assign trial = res_i + BIT_VAL;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_i >= trial) begin
                    rem_reg[i] <= rem_i - trial;
                    res_reg[i] <= (res_i >> 1) + BIT_VAL;
                end else begin
                    rem_reg[i] <= rem_i;
                    res_reg[i] <= res_i >> 1;
                end
            end
        end
    end

    // round to nearest: remainder above root means past the half point
    logic [SW-1:0] rounded;

    assign rounded = res_reg[NS-1] + SW'(rem_reg[NS-1] > res_reg[NS-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            out_radius <= rounded[COORD_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire
